// ===== rtl/i32v_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i32v_pkg
// Shared types, constants and operation codes of the four-lane integer
// vector ALU.
// ----------------------------------------------------------------------------
package i32v_pkg;

    // Lane geometry
    localparam int LANE_COUNT = 4;
    localparam int LANE_W     = 32;
    localparam int LANE_BITS  = $clog2(LANE_COUNT);
    localparam int MODE_W     = 5;
    localparam int SHAMT_W    = 5;
    // Shuffle mask spans one lane selector per lane
    localparam int SHUF_MASK_W = LANE_COUNT * LANE_BITS;

    localparam logic [LANE_W-1:0] LANE_ONES = {LANE_W{1'b1}};
    localparam logic [LANE_W-1:0] LANE_ZERO = '0;

    typedef logic [LANE_COUNT-1:0][LANE_W-1:0] lane_vec_t;

    // Operation codes
    typedef enum logic [MODE_W-1:0] {
        OP_ADD      = 5'd0,
        OP_SUB      = 5'd1,
        OP_MUL      = 5'd2,
        OP_AND      = 5'd3,
        OP_OR       = 5'd4,
        OP_XOR      = 5'd5,
        OP_NOT      = 5'd6,
        OP_NEG      = 5'd7,
        OP_LT       = 5'd8,
        OP_LE       = 5'd9,
        OP_GT       = 5'd10,
        OP_GE       = 5'd11,
        OP_EQ       = 5'd12,
        OP_NE       = 5'd13,
        OP_SHL      = 5'd14,
        OP_SRA      = 5'd15,
        OP_SRL      = 5'd16,
        OP_SHUF1    = 5'd17,
        OP_SHUF2    = 5'd18,
        OP_BITSEL   = 5'd19,
        OP_REPLACE  = 5'd20,
        OP_FLAG     = 5'd21,
        OP_SPLAT    = 5'd22,
        OP_ZERO     = 5'd23,
        OP_BOOL     = 5'd24,
        OP_SIGNMASK = 5'd25
    } mode_t;

    // Per-lane registered result
    typedef struct packed {
        logic [LANE_W-1:0] value;
        logic              sign;
    } lane_out_t;

    // Control carried alongside the lane stage
    typedef struct packed {
        logic valid;
        logic pack_signs;
        logic bad;
    } ctrl_t;

endpackage : i32v_pkg
`default_nettype wire

// ===== rtl/i32v_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i32v_lane
// One 32-bit lane: computes the lane's result for every operation and
// registers it together with the sign bit of its a element.
// ----------------------------------------------------------------------------
module i32v_lane (
    input  wire logic                        clk,
    input  wire logic [i32v_pkg::LANE_BITS-1:0] lane_id,
    input  wire logic [i32v_pkg::MODE_W-1:0] mode,
    input  wire i32v_pkg::lane_vec_t         a,
    input  wire i32v_pkg::lane_vec_t         b,
    input  wire logic [i32v_pkg::LANE_W-1:0] c_elem,
    input  wire logic [i32v_pkg::LANE_W-1:0] scalar,
    input  wire logic [i32v_pkg::LANE_BITS-1:0] lane_index,
    output i32v_pkg::lane_out_t              lane_out
);
    import i32v_pkg::*;

    logic [LANE_W-1:0]    a_elem;
    logic [LANE_W-1:0]    b_elem;
    logic [SHAMT_W-1:0]   shamt;
    logic [LANE_BITS-1:0] shuf_src;
    logic                 use_b;
    logic [LANE_W-1:0]    value_next;
    lane_out_t            lane_reg;

    assign a_elem = a[lane_id];
    assign b_elem = b[lane_id];
    assign shamt  = scalar[SHAMT_W-1:0];

    // Shuffle source lane: selector field of this lane in the mask
    assign shuf_src = scalar[lane_id * LANE_BITS +: LANE_BITS];
    assign use_b    = (mode_t'(mode) == OP_SHUF2) &&
                      ({1'b0, lane_id} >= (LANE_BITS+1)'(LANE_COUNT / 2));

    // Lane operation
    always_comb
    begin
        unique case (mode_t'(mode))
            OP_ADD:      value_next = a_elem + b_elem;
            OP_SUB:      value_next = a_elem - b_elem;
            OP_MUL:      value_next = a_elem * b_elem;
            OP_AND:      value_next = a_elem & b_elem;
            OP_OR:       value_next = a_elem | b_elem;
            OP_XOR:      value_next = a_elem ^ b_elem;
            OP_NOT:      value_next = ~a_elem;
            OP_NEG:      value_next = LANE_ZERO - a_elem;
            OP_LT:       value_next = ($signed(a_elem) <  $signed(b_elem)) ? LANE_ONES : LANE_ZERO;
            OP_LE:       value_next = ($signed(a_elem) <= $signed(b_elem)) ? LANE_ONES : LANE_ZERO;
            OP_GT:       value_next = ($signed(a_elem) >  $signed(b_elem)) ? LANE_ONES : LANE_ZERO;
            OP_GE:       value_next = ($signed(a_elem) >= $signed(b_elem)) ? LANE_ONES : LANE_ZERO;
            OP_EQ:       value_next = (a_elem == b_elem) ? LANE_ONES : LANE_ZERO;
            OP_NE:       value_next = (a_elem != b_elem) ? LANE_ONES : LANE_ZERO;
            OP_SHL:      value_next = a_elem << shamt;
            OP_SRA:      value_next = LANE_W'($signed(a_elem) >>> shamt);
            OP_SRL:      value_next = a_elem >> shamt;
            OP_SHUF1,
            OP_SHUF2:    value_next = use_b ? b[shuf_src] : a[shuf_src];
            OP_BITSEL:   value_next = (a_elem & b_elem) | (~a_elem & c_elem);
            OP_REPLACE:  value_next = (lane_id == lane_index) ? scalar : a_elem;
            OP_FLAG:     value_next = (lane_id != lane_index) ? a_elem :
                                      ((scalar != LANE_ZERO) ? LANE_ONES : LANE_ZERO);
            OP_SPLAT:    value_next = scalar;
            OP_BOOL:     value_next = scalar[lane_id] ? LANE_ONES : LANE_ZERO;
            // zero, sign mask (built in the merge stage) and unused codes
            default:     value_next = LANE_ZERO;
        endcase
    end

    // Lane result register
    always_ff @(posedge clk)
    begin
        lane_reg.value <= value_next;
        lane_reg.sign  <= a_elem[LANE_W-1];
    end

    assign lane_out = lane_reg;

endmodule : i32v_lane
`default_nettype wire

// ===== rtl/i32v_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i32v_merge
// Combines the lane results: builds the sign mask, zeroes the vector on a
// bad shuffle mask, and drives the output register and strobe.
// ----------------------------------------------------------------------------
module i32v_merge (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire i32v_pkg::ctrl_t                       ctrl,
    input  wire i32v_pkg::lane_out_t [i32v_pkg::LANE_COUNT-1:0] lanes,
    output logic                                       done,
    output i32v_pkg::lane_vec_t                        result,
    output logic                                       bad_argument
);
    import i32v_pkg::*;

    logic [LANE_COUNT-1:0] signs;
    lane_vec_t             result_next;
    lane_vec_t             result_reg;
    logic                  done_reg;
    logic                  bad_reg;

    // Merge lane values
    always_comb
    begin
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            signs[i]       = lanes[i].sign;
            result_next[i] = lanes[i].value;
        end
        if (ctrl.pack_signs)
        begin
            result_next    = '0;
            result_next[0] = LANE_W'(signs);
        end
        if (ctrl.bad)
        begin
            result_next = '0;
        end
    end

    // Output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.valid;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        bad_reg    <= ctrl.bad;
    end

    assign done         = done_reg;
    assign result       = result_reg;
    assign bad_argument = bad_reg;

endmodule : i32v_merge
`default_nettype wire

// ===== rtl/int32x4_vector_alu_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// int32x4_vector_alu_core
// Four-lane 32-bit integer vector ALU, one operation per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is accepted on a rising edge with start high and busy low.
//   busy is never asserted: a new transaction may be issued every cycle.
//   Each transaction yields one result on result_lo, result_hi and
//   bad_argument, valid for exactly one cycle while done is high.
//   Each transaction passes the lane units (one 32x32 multiplier per lane
//   bounds this stage), then the merge stage. Throughput is one
//   transaction per cycle, results leave in issue order.
//   The receiver cannot stall; results must be taken when done is high.
//   Reset (rst_n low, asynchronous) clears the pipeline valid bits, so no
//   done strobe follows reset. The data registers are not reset.
//   bad_argument flags a shuffle mask outside 0..255; the vector is zero.
// ----------------------------------------------------------------------------
module int32x4_vector_alu_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [4:0]  mode,
    input  wire logic [63:0] a_lo,
    input  wire logic [63:0] a_hi,
    input  wire logic [63:0] b_lo,
    input  wire logic [63:0] b_hi,
    input  wire logic [63:0] c_lo,
    input  wire logic [63:0] c_hi,
    input  wire logic signed [31:0] scalar,
    input  wire logic [1:0]  lane_index,
    output logic             done,
    output logic [63:0]      result_lo,
    output logic [63:0]      result_hi,
    output logic             bad_argument
);
    import i32v_pkg::*;

    lane_vec_t                    a_vec;
    lane_vec_t                    b_vec;
    lane_vec_t                    c_vec;
    lane_vec_t                    result;
    lane_out_t [LANE_COUNT-1:0]   lanes;
    logic                         accept;
    logic                         is_shuffle;
    ctrl_t                        ctrl_next;
    ctrl_t                        ctrl_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign a_vec = {a_hi, a_lo};
    assign b_vec = {b_hi, b_lo};
    assign c_vec = {c_hi, c_lo};

    // Control for the merge stage
    assign is_shuffle = (mode_t'(mode) == OP_SHUF1) || (mode_t'(mode) == OP_SHUF2);
    always_comb
    begin
        ctrl_next.valid      = accept;
        ctrl_next.pack_signs = (mode_t'(mode) == OP_SIGNMASK);
        ctrl_next.bad        = is_shuffle && (scalar[LANE_W-1:SHUF_MASK_W] != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    // Lane units
    for (genvar g = 0; g < LANE_COUNT; g++)
    begin : g_lane
        i32v_lane u_lane (
            .clk        (clk),
            .lane_id    (LANE_BITS'(g)),
            .mode       (mode),
            .a          (a_vec),
            .b          (b_vec),
            .c_elem     (c_vec[g]),
            .scalar     (scalar),
            .lane_index (lane_index),
            .lane_out   (lanes[g])
        );
    end

    // Merge and output register
    i32v_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl_reg),
        .lanes        (lanes),
        .done         (done),
        .result       (result),
        .bad_argument (bad_argument)
    );

    assign result_lo = {result[1], result[0]};
    assign result_hi = {result[3], result[2]};

endmodule : int32x4_vector_alu_core
`default_nettype wire

// ===== tb/int32x4_vector_alu_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int32x4_vector_alu_core_tb
// Self-checking bench for the four-lane 32-bit integer vector ALU. Directed
// transactions cover every operation, the field extremes, masked shift
// amounts, out-of-range shuffle masks and an unused operation code. Long
// random runs follow, gapped and then back to back. Each accepted transaction is
// predicted in the bench and checked against the done-strobed result, in order.
// ----------------------------------------------------------------------------
module int32x4_vector_alu_core_tb;

    import i32v_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int REPORT_LIMIT   = 10;
    localparam int GAPPED_ITEMS   = 600;
    localparam int STREAM_ITEMS   = 350;
    localparam logic [4:0] MODE_MAX = 5'd31;

    // One operation as presented on the input ports
    typedef struct packed {
        logic [4:0]  mode;
        logic [63:0] a_lo;
        logic [63:0] a_hi;
        logic [63:0] b_lo;
        logic [63:0] b_hi;
        logic [63:0] c_lo;
        logic [63:0] c_hi;
        logic [31:0] scalar;
        logic [1:0]  lane_index;
    } alu_op_t;

    // Predicted result vector and error flag
    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        bad;
    } alu_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [4:0]         mode;
    logic [63:0]        a_lo;
    logic [63:0]        a_hi;
    logic [63:0]        b_lo;
    logic [63:0]        b_hi;
    logic [63:0]        c_lo;
    logic [63:0]        c_hi;
    logic signed [31:0] scalar;
    logic [1:0]         lane_index;
    logic               done;
    logic [63:0]        result_lo;
    logic [63:0]        result_hi;
    logic               bad_argument;

    alu_result_t pending_vectors[$];
    int          mismatch_count;
    int          idle_cycle_count;
    bit          gaps_on;

    int32x4_vector_alu_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .a_lo         (a_lo),
        .a_hi         (a_hi),
        .b_lo         (b_lo),
        .b_hi         (b_hi),
        .c_lo         (c_lo),
        .c_hi         (c_hi),
        .scalar       (scalar),
        .lane_index   (lane_index),
        .done         (done),
        .result_lo    (result_lo),
        .result_hi    (result_hi),
        .bad_argument (bad_argument)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Lane-wise prediction of one operation
    // ------------------------------------------------------------------------
    function automatic alu_result_t predict_alu_result(input alu_op_t op);
        lane_vec_t   va;
        lane_vec_t   vb;
        lane_vec_t   vc;
        lane_vec_t   vr;
        logic [31:0] s;
        logic [4:0]  amt;
        logic [1:0]  src;
        logic        mask_bad;
        logic        shuffle;
        alu_result_t res;
        va       = {op.a_hi, op.a_lo};
        vb       = {op.b_hi, op.b_lo};
        vc       = {op.c_hi, op.c_lo};
        vr       = '0;
        s        = op.scalar;
        amt      = s[4:0];
        // mask must lie in 0..255: sign clear and nothing above bit 7
        mask_bad = s[31] || (s[30:8] != '0);
        shuffle  = (op.mode == OP_SHUF1) || (op.mode == OP_SHUF2);
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            case (op.mode)
                OP_ADD:   vr[i] = va[i] + vb[i];
                OP_SUB:   vr[i] = va[i] - vb[i];
                OP_MUL:   vr[i] = va[i] * vb[i];
                OP_AND:   vr[i] = va[i] & vb[i];
                OP_OR:    vr[i] = va[i] | vb[i];
                OP_XOR:   vr[i] = va[i] ^ vb[i];
                OP_NOT:   vr[i] = ~va[i];
                OP_NEG:   vr[i] = LANE_ZERO - va[i];
                OP_LT:    vr[i] = ($signed(va[i]) <  $signed(vb[i])) ? LANE_ONES : LANE_ZERO;
                OP_LE:    vr[i] = ($signed(va[i]) <= $signed(vb[i])) ? LANE_ONES : LANE_ZERO;
                OP_GT:    vr[i] = ($signed(va[i]) >  $signed(vb[i])) ? LANE_ONES : LANE_ZERO;
                OP_GE:    vr[i] = ($signed(va[i]) >= $signed(vb[i])) ? LANE_ONES : LANE_ZERO;
                OP_EQ:    vr[i] = (va[i] == vb[i]) ? LANE_ONES : LANE_ZERO;
                OP_NE:    vr[i] = (va[i] != vb[i]) ? LANE_ONES : LANE_ZERO;
                OP_SHL:   vr[i] = va[i] << amt;
                OP_SRA:   vr[i] = $signed(va[i]) >>> amt;
                OP_SRL:   vr[i] = va[i] >> amt;
                OP_SHUF1, OP_SHUF2:
                begin
                    src = s[2*i +: 2];
                    // two-vector form draws the upper half from b
                    if (op.mode == OP_SHUF2 && i >= LANE_COUNT / 2)
                        vr[i] = vb[src];
                    else
                        vr[i] = va[src];
                end
                OP_BITSEL:  vr[i] = (va[i] & vb[i]) | (~va[i] & vc[i]);
                OP_REPLACE: vr[i] = (i == op.lane_index) ? s : va[i];
                OP_FLAG:
                begin
                    if (i == op.lane_index)
                        vr[i] = (s != '0) ? LANE_ONES : LANE_ZERO;
                    else
                        vr[i] = va[i];
                end
                OP_SPLAT: vr[i] = s;
                OP_ZERO:  vr[i] = LANE_ZERO;
                OP_BOOL:  vr[i] = s[i] ? LANE_ONES : LANE_ZERO;
                OP_SIGNMASK:
                begin
                    if (i == 0)
                        vr[0] = {28'd0, va[3][31], va[2][31], va[1][31], va[0][31]};
                end
                default:  vr[i] = LANE_ZERO;
            endcase
        end
        res.bad = shuffle && mask_bad;
        if (res.bad)
            vr = '0;
        res.lo = vr[1:0];
        res.hi = vr[3:2];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Issue one transaction; entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_op(input logic [4:0] m, input lane_vec_t va, input lane_vec_t vb,
                           input lane_vec_t vc, input logic [31:0] s, input logic [1:0] li);
        alu_op_t op;
        op.mode       = m;
        op.a_lo       = va[1:0];
        op.a_hi       = va[3:2];
        op.b_lo       = vb[1:0];
        op.b_hi       = vb[3:2];
        op.c_lo       = vc[1:0];
        op.c_hi       = vc[3:2];
        op.scalar     = s;
        op.lane_index = li;
        if (gaps_on && $urandom_range(3, 0) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(8, 1)) @(negedge clk);
        end
        mode       <= op.mode;
        a_lo       <= op.a_lo;
        a_hi       <= op.a_hi;
        b_lo       <= op.b_lo;
        b_hi       <= op.b_hi;
        c_lo       <= op.c_lo;
        c_hi       <= op.c_hi;
        scalar     <= op.scalar;
        lane_index <= op.lane_index;
        start      <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_vectors.push_back(predict_alu_result(op));
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Random operands, biased toward lane corner values
    // ------------------------------------------------------------------------
    function automatic logic [31:0] rand_lane();
        case ($urandom_range(7, 0))
            0:       return LANE_ZERO;
            1:       return LANE_ONES;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic lane_vec_t rand_vec();
        lane_vec_t v;
        for (int i = 0; i < LANE_COUNT; i++)
            v[i] = rand_lane();
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    task automatic test_arith_logic();
        lane_vec_t x;
        lane_vec_t y;
        x = {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};
        y = {32'h0000_0002, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001};
        // wrap at both ends of the signed and unsigned ranges
        send_op(OP_ADD, x, y, '0, '0, 2'd0);
        send_op(OP_SUB, x, y, '0, '0, 2'd0);
        send_op(OP_MUL, x, y, '0, '0, 2'd0);
        send_op(OP_AND, x, {4{32'hA5A5_5A5A}}, '0, '0, 2'd0);
        send_op(OP_OR,  x, {4{32'h0F0F_F0F0}}, '0, '0, 2'd0);
        send_op(OP_XOR, x, {4{32'hFFFF_0000}}, '0, '0, 2'd0);
        send_op(OP_NOT, x, '0, '0, '0, 2'd0);
        send_op(OP_NEG, x, '0, '0, '0, 2'd0);
    endtask

    task automatic test_compares();
        lane_vec_t x;
        lane_vec_t y;
        // lane 3 less, lane 2 equal, lane 1 greater, lane 0 max against min
        x = {32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0005, 32'h7FFF_FFFF};
        y = {32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000};
        for (int m = OP_LT; m <= OP_NE; m++)
            send_op(m[4:0], x, y, '0, '0, 2'd0);
    endtask

    task automatic test_shifts();
        lane_vec_t x;
        x = {32'h8000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001};
        // amount taken from the low five bits of the scalar only
        send_op(OP_SHL, x, '0, '0, 32'd33, 2'd0);
        send_op(OP_SRA, x, '0, '0, 32'd31, 2'd0);
        send_op(OP_SRL, x, '0, '0, 32'hFFFF_FFFF, 2'd0);
    endtask

    task automatic test_shuffles();
        lane_vec_t x;
        lane_vec_t y;
        x = {32'hA3A3_A3A3, 32'hA2A2_A2A2, 32'hA1A1_A1A1, 32'hA0A0_A0A0};
        y = {32'hB3B3_B3B3, 32'hB2B2_B2B2, 32'hB1B1_B1B1, 32'hB0B0_B0B0};
        send_op(OP_SHUF1, x, y, '0, 32'h0000_001B, 2'd0);
        send_op(OP_SHUF2, x, y, '0, 32'h0000_00FF, 2'd0);
        // masks just past each end of the legal range
        send_op(OP_SHUF1, x, y, '0, 32'h0000_0100, 2'd0);
        send_op(OP_SHUF2, x, y, '0, 32'hFFFF_FFFF, 2'd0);
    endtask

    task automatic test_lane_ops();
        lane_vec_t x;
        x = {32'h8000_0000, 32'h0123_4567, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
        send_op(OP_BITSEL, x, {4{32'hFFFF_FFFF}}, {4{32'h5555_5555}}, '0, 2'd0);
        send_op(OP_REPLACE, x, '0, '0, 32'h8000_0000, 2'd3);
        send_op(OP_FLAG, x, '0, '0, 32'h0000_0000, 2'd2);
        send_op(OP_SPLAT, x, '0, '0, 32'h7FFF_FFFF, 2'd0);
        send_op(OP_ZERO, x, x, x, 32'hFFFF_FFFF, 2'd1);
        send_op(OP_BOOL, x, '0, '0, 32'h0000_000A, 2'd0);
        send_op(OP_SIGNMASK, x, '0, '0, '0, 2'd0);
        // codes past the last operation give a zero vector
        send_op(MODE_MAX, x, x, x, 32'hFFFF_FFFF, 2'd3);
    endtask

    // ------------------------------------------------------------------------
    // Random operations; gaps come and go in stretches when allowed
    // ------------------------------------------------------------------------
    task automatic test_random_ops(input int count, input bit with_gaps);
        logic [4:0]  m;
        lane_vec_t   va;
        lane_vec_t   vb;
        logic [31:0] s;
        for (int n = 0; n < count; n++)
        begin
            gaps_on = with_gaps && ((n / 48) % 3 != 2);
            if ($urandom_range(39, 0) == 0)
                m = 5'($urandom_range(MODE_MAX, OP_SIGNMASK + 1));
            else
                m = 5'($urandom_range(OP_SIGNMASK, OP_ADD));
            va = rand_vec();
            vb = rand_vec();
            s  = $urandom;
            case (m)
                OP_LT, OP_LE, OP_GT, OP_GE, OP_EQ, OP_NE:
                begin
                    // pull some lanes close to each other so ties are common
                    for (int i = 0; i < LANE_COUNT; i++)
                        case ($urandom_range(3, 0))
                            0: vb[i] = va[i];
                            1: vb[i] = va[i] + 32'd1;
                            2: vb[i] = va[i] - 32'd1;
                            default: ;
                        endcase
                end
                OP_SHUF1, OP_SHUF2:
                begin
                    case ($urandom_range(7, 0))
                        0:       s = 32'h0000_0100;
                        1:       s = 32'hFFFF_FFFF;
                        2:       ;
                        default: s = $urandom_range(255, 0);
                    endcase
                end
                OP_FLAG, OP_REPLACE:
                begin
                    if ($urandom_range(2, 0) == 0)
                        s = '0;
                end
                default: ;
            endcase
            send_op(m, va, vb, rand_vec(), s, 2'($urandom_range(3, 0)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: each done strobe against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        alu_result_t want;
        if (rst_n && done)
        begin
            if (pending_vectors.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result with no transaction pending: lo=%h hi=%h bad=%b",
                             $realtime, result_lo, result_hi, bad_argument);
            end
            else
            begin
                want = pending_vectors.pop_front();
                if (result_lo !== want.lo || result_hi !== want.hi
                    || bad_argument !== want.bad)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: mismatch: exp lo=%h hi=%h bad=%b, got lo=%h hi=%h bad=%b",
                                 $realtime, want.lo, want.hi, want.bad,
                                 result_lo, result_hi, bad_argument);
                end
            end
        end
    end

    // Watchdog: cycles with neither an accepted transaction nor a result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycle_count <= 0;
        else
            idle_cycle_count <= idle_cycle_count + 1;
        if (idle_cycle_count >= STALL_LIMIT)
        begin
            $display("int32x4_vector_alu_core_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        mismatch_count   = 0;
        idle_cycle_count = 0;
        gaps_on          = 1'b0;
        rst_n            = 1'b0;
        start            = 1'b0;
        mode             = '0;
        a_lo             = '0;
        a_hi             = '0;
        b_lo             = '0;
        b_hi             = '0;
        c_lo             = '0;
        c_hi             = '0;
        scalar           = '0;
        lane_index       = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        gaps_on = 1'b1;
        test_arith_logic();
        test_compares();
        test_shifts();
        test_shuffles();
        test_lane_ops();
        test_random_ops(GAPPED_ITEMS, 1'b1);
        // closing stretch issues back to back
        test_random_ops(STREAM_ITEMS, 1'b0);
        start <= 1'b0;

        while (pending_vectors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_vectors.size() == 0)
            $display("int32x4_vector_alu_core_tb: done, clean");
        else
            $display("int32x4_vector_alu_core_tb: done, errors");
        $finish;
    end

endmodule
